@@ src/tam_pkg.sv @@
// Shared constants and types for the three-axis trimmed mean block.
// Used by the channel interfaces, the axis cell and the top level.
package tam_pkg;

  // Width of one sample and of one mean
  localparam int SAMPLE_W = 16;

  // Default log2 of the number of values kept per window
  localparam int KEPT_LOG2_DEF = 3;

  // Per-item strobes from the window control to every axis cell
  typedef struct packed {
    logic acc_en;   // item accepted: fold the sample into the running state
    logic first;    // item opens a window
    logic fin_en;   // item closes a window: capture sum, min and max
    logic kep_en;   // form the trimmed sum
    logic out_en;   // form the mean into the result register
  } tam_ctl_t;

endpackage

@@ src/tam_if.sv @@
// Valid/ready channel interfaces for sample items and mean items.
// Depends on tam_pkg for the sample width.
interface tam_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tam_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [tam_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [tam_pkg::SAMPLE_W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tam_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tam_pkg::SAMPLE_W-1:0] mean_x;
  logic signed [tam_pkg::SAMPLE_W-1:0] mean_y;
  logic signed [tam_pkg::SAMPLE_W-1:0] mean_z;

  modport source (output valid, output mean_x, output mean_y, output mean_z,
                  input ready);
  modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                  output ready);
endinterface

@@ src/tam_cell.sv @@
// One axis cell: running sum/min/max over a window, then trim and divide.
// Depends on tam_pkg; strobes come from the window control in the top level.
module tam_cell #(
  parameter int KEPT_LOG2 = tam_pkg::KEPT_LOG2_DEF
) (
  input  logic                                clk,
  input  tam_pkg::tam_ctl_t                   ctl,
  input  logic signed [tam_pkg::SAMPLE_W-1:0] sample,
  output logic signed [tam_pkg::SAMPLE_W-1:0] mean
);
  import tam_pkg::*;

  // Window of 2^K+2 values does not exceed 2^(K+1) for K >= 1, so K+1 guard bits suffice
  localparam int SUM_W = SAMPLE_W + KEPT_LOG2 + 1;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((1 << KEPT_LOG2) - 1);

  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic signed [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic signed [SUM_W-1:0]    fin_sum_r;
  logic signed [SAMPLE_W-1:0] fin_lo_r, fin_hi_r;
  logic signed [SUM_W-1:0]    kept_r, kept_nxt;
  logic signed [SUM_W-1:0]    biased;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic signed [SUM_W-1:0]    sample_ext;

  // Running state update; first item of a window reloads it
  always_comb begin
    sample_ext = SUM_W'(sample);
    if (ctl.first) begin
      sum_nxt = sample_ext;
      lo_nxt  = sample;
      hi_nxt  = sample;
    end else begin
      sum_nxt = sum_r + sample_ext;
      lo_nxt  = (sample < lo_r) ? sample : lo_r;
      hi_nxt  = (sample > hi_r) ? sample : hi_r;
    end
  end

  // Drop one min and one max; the result fits well inside SUM_W
  assign kept_nxt = fin_sum_r - SUM_W'(fin_lo_r) - SUM_W'(fin_hi_r);

  // Divide by 2^K truncating toward zero: bias negatives before the shift
  assign biased = kept_r + (kept_r[SUM_W-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      sum_r <= sum_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
    if (ctl.fin_en) begin
      fin_sum_r <= sum_nxt;
      fin_lo_r  <= lo_nxt;
      fin_hi_r  <= hi_nxt;
    end
    if (ctl.kep_en) begin
      kept_r <= kept_nxt;
    end
    if (ctl.out_en) begin
      mean_r <= biased[KEPT_LOG2 +: SAMPLE_W];
    end
  end

  assign mean = mean_r;

endmodule

@@ src/three_axis_trimmed_mean.sv @@
// Top level of the three-axis trimmed mean: window control, result pipeline
// valids and a row of three axis cells. Depends on tam_pkg, tam_if, tam_cell.
//
//  channel   dir  handshake     payload
//  in_item   in   valid/ready   sample_x, sample_y, sample_z (s16)
//  out_item  out  valid/ready   mean_x, mean_y, mean_z (s16)
//
// One item per cycle is accepted. Every 2^KEPT_LOG2+2 items close a window;
// its result passes the capture, trim and divide stages, each a register,
// before it is offered. in_item.ready drops only while the capture stage
// holds a result that cannot move on because out_item stalls.
// Reset clears the window position and all stage valids.
module three_axis_trimmed_mean #(
  parameter int KEPT_LOG2 = tam_pkg::KEPT_LOG2_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tam_in_if.sink     in_item,
  tam_out_if.source  out_item
);
  import tam_pkg::*;

  localparam int WIN   = (1 << KEPT_LOG2) + 2;
  localparam int POS_W = $clog2(WIN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WIN - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fin_vld_r, kep_vld_r, out_vld_r;
  logic             in_fire, is_last;
  logic             fin_load, kep_load, out_load;
  tam_ctl_t         ctl;

  // Stage advance: each stage moves when the next is empty or moving
  assign out_load = kep_vld_r && (!out_vld_r || out_item.ready);
  assign kep_load = fin_vld_r && (!kep_vld_r || out_load);
  assign in_item.ready = !fin_vld_r || kep_load;
  assign in_fire  = in_item.valid && in_item.ready;
  assign is_last  = (pos_r == POS_LAST);
  assign fin_load = in_fire && is_last;

  // Window position
  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      pos_nxt = is_last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fin_vld_r <= 1'b0;
      kep_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (fin_load) begin
        fin_vld_r <= 1'b1;
      end else if (kep_load) begin
        fin_vld_r <= 1'b0;
      end
      if (kep_load) begin
        kep_vld_r <= 1'b1;
      end else if (out_load) begin
        kep_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_item.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Strobes shared by all cells
  always_comb begin
    ctl.acc_en = in_fire;
    ctl.first  = (pos_r == '0);
    ctl.fin_en = fin_load;
    ctl.kep_en = kep_load;
    ctl.out_en = out_load;
  end

  // Row of axis cells
  tam_cell #(.KEPT_LOG2(KEPT_LOG2)) u_cell_x (
    .clk(clk), .ctl(ctl), .sample(in_item.sample_x), .mean(out_item.mean_x)
  );
  tam_cell #(.KEPT_LOG2(KEPT_LOG2)) u_cell_y (
    .clk(clk), .ctl(ctl), .sample(in_item.sample_y), .mean(out_item.mean_y)
  );
  tam_cell #(.KEPT_LOG2(KEPT_LOG2)) u_cell_z (
    .clk(clk), .ctl(ctl), .sample(in_item.sample_z), .mean(out_item.mean_z)
  );

  assign out_item.valid = out_vld_r;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("window position out of range");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |-> (!fin_vld_r || kep_load))
    else $error("window closed while capture stage is occupied");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(kep_vld_r))
    else $error("result offered without a trimmed sum behind it");

endmodule
